// ----- design/ilt_pkg.sv -----
// ilt_pkg: shared constants and types for the integer list tokenizer
// no dependencies; compile first

package ilt_pkg;

  // default width of the signed result number
  localparam int unsigned VALUE_BITS_DEF = 32;

  // character codes the parser reacts to
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // multiplier of the decimal accumulate
  localparam int unsigned RADIX = 10;

  // parse phase of the current number
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SIGN,
    PH_DIGITS
  } phase_e;

endpackage

// ----- design/ilt_if.sv -----
// ilt_if: valid/ready channel interfaces of the integer list tokenizer
// ilt_char_if carries text bytes, ilt_res_if carries parse results; no dependencies

interface ilt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ilt_res_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         value_valid;
  logic signed [VALUE_BITS-1:0] number;
  logic                         row_end;
  logic                         list_end;

  modport source (output valid, output value_valid, output number, output row_end,
                  output list_end, input ready);
  modport sink   (input valid, input value_valid, input number, input row_end,
                  input list_end, output ready);
endinterface

// ----- design/integer_list_tokenizer.sv -----
// integer_list_tokenizer: byte-serial signed decimal integer list parser
// depends on ilt_pkg (constants, phase_e) and ilt_if (channel interfaces)
//
// The block takes one text byte per clock cycle and returns signed decimal
// integers; whitespace, commas and other junk give nothing, a sign counts
// only when a digit follows, an out-of-range value is returned as 0.
// Setting matrix_mode makes ';' close a row. The byte with is_last always
// produces one result with list_end set. A byte is registered in the input
// register on acceptance and fully parsed from there (multiply-by-ten
// accumulate and phase update) once the result register can take its
// result, which is then loaded into the result register. Sustained
// throughput is one byte per cycle; it is limited by the single result
// register only while the result sink stalls.

module integer_list_tokenizer
  import ilt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  ilt_char_if.sink   char_i,
  ilt_res_if.source  res_o
);

  localparam int unsigned ACC_BITS = VALUE_BITS + 4;
  localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (VALUE_BITS - 1);
  localparam logic [ACC_BITS-1:0] LIM_POS = HALF - ACC_BITS'(1);

  // configuration
  logic matrix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= 1'b0;
    end else if (cfg_we_i) begin
      matrix_q <= cfg_wdata_i;
    end
  end

  // input register
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       step;
  logic       in_take;

  assign char_i.ready = !in_vld_q || step;
  assign in_take      = char_i.valid && char_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= char_i.char_code;
      in_last_q <= char_i.is_last;
    end
  end

  // parse state
  phase_e                phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  oor_q, oor_d;

  // byte classification
  logic       is_digit;
  logic       is_sign;
  logic [3:0] digit;

  assign is_digit = (in_char_q >= CH_ZERO) && (in_char_q <= CH_NINE);
  assign is_sign  = (in_char_q == CH_PLUS) || (in_char_q == CH_MINUS);
  assign digit    = in_char_q[3:0];

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (in_last_q) begin
      phase_d = PH_IDLE;
    end else if (is_digit) begin
      phase_d = PH_DIGITS;
    end else if (is_sign) begin
      phase_d = PH_SIGN;
    end else begin
      phase_d = PH_IDLE;
    end
  end

  // decimal accumulate with range check
  logic                  acc_neg;
  logic [VALUE_BITS-1:0] acc_base;
  logic                  acc_oor_base;
  logic [ACC_BITS-1:0]   acc_lim;
  logic [ACC_BITS-1:0]   acc_sum;
  logic                  acc_over;
  logic [VALUE_BITS-1:0] acc_mag;
  logic                  acc_oor;

  always_comb begin
    acc_neg      = (phase_q == PH_IDLE) ? 1'b0 : neg_q;
    acc_base     = (phase_q == PH_DIGITS) ? mag_q : '0;
    acc_oor_base = (phase_q == PH_DIGITS) ? oor_q : 1'b0;
    acc_lim      = acc_neg ? HALF : LIM_POS;
    acc_sum      = (ACC_BITS'(acc_base) << 3) + (ACC_BITS'(acc_base) << 1)
                 + ACC_BITS'(digit);
    acc_over     = acc_sum > acc_lim;
    acc_oor      = acc_oor_base || acc_over;
    acc_mag      = acc_oor ? acc_base : acc_sum[VALUE_BITS-1:0];
  end

  // next number state
  always_comb begin
    neg_d = neg_q;
    mag_d = mag_q;
    oor_d = oor_q;
    if (in_last_q) begin
      neg_d = 1'b0;
      mag_d = '0;
      oor_d = 1'b0;
    end else if (is_digit) begin
      neg_d = acc_neg;
      mag_d = acc_mag;
      oor_d = acc_oor;
    end else begin
      neg_d = is_sign && (in_char_q == CH_MINUS);
      mag_d = '0;
      oor_d = 1'b0;
    end
  end

  // result of this byte
  logic                  emit_old;
  logic                  emit_new;
  logic                  fin_neg;
  logic [VALUE_BITS-1:0] fin_mag;
  logic                  fin_oor;
  logic                  r_value_valid;
  logic [VALUE_BITS-1:0] r_number;
  logic                  r_row_end;
  logic                  r_present;

  always_comb begin
    emit_old      = !is_digit && (phase_q == PH_DIGITS);
    emit_new      = is_digit && in_last_q;
    fin_neg       = emit_new ? acc_neg : neg_q;
    fin_mag       = emit_new ? acc_mag : mag_q;
    fin_oor       = emit_new ? acc_oor : oor_q;
    r_value_valid = emit_old || emit_new;
    if (!r_value_valid || fin_oor) begin
      r_number = '0;
    end else begin
      r_number = fin_neg ? (~fin_mag + VALUE_BITS'(1)) : fin_mag;
    end
    r_row_end = matrix_q && ((in_char_q == CH_SEMI) || in_last_q);
    r_present = r_value_valid || r_row_end || in_last_q;
  end

  // one byte is parsed when the result register can take its result
  assign step = in_vld_q && (!r_present || !res_o.valid || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      oor_q   <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      oor_q   <= oor_d;
    end
  end

  // result register
  logic                  res_vld_q;
  logic                  res_value_valid_q;
  logic [VALUE_BITS-1:0] res_number_q;
  logic                  res_row_end_q;
  logic                  res_list_end_q;
  logic                  res_load;

  assign res_load = step && r_present;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_load) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_value_valid_q <= r_value_valid;
      res_number_q      <= r_number;
      res_row_end_q     <= r_row_end;
      res_list_end_q    <= in_last_q;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.value_valid = res_value_valid_q;
  assign res_o.number      = res_number_q;
  assign res_o.row_end     = res_row_end_q;
  assign res_o.list_end    = res_list_end_q;

  // checks
  a_no_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_value_valid_q |-> res_number_q == '0)
    else $error("result without value carries a nonzero number");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_last_q |=> phase_q == PH_IDLE && !oor_q && mag_q == '0)
    else $error("parse state not cleared after final byte");

  a_mag_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIGITS |-> ACC_BITS'(mag_q) <= HALF)
    else $error("accumulated magnitude beyond signed range");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_o.ready |=> res_vld_q)
    else $error("pending result dropped while stalled");

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for integer_list_tokenizer
// depends on ilt_pkg and ilt_if from the design folder; streams text bytes with random
// idling on both channels and checks every parse result against a local parser model

module tb_top;
  import ilt_pkg::*;

  localparam int unsigned NUM_BITS     = VALUE_BITS_DEF;
  localparam int unsigned SEGMENTS     = 12;
  localparam int unsigned SEG_BYTES    = 100;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_PRINTS   = 40;

  // text bytes used by the stimulus beyond the package codes
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef struct packed {
    logic                       value_valid;
    logic signed [NUM_BITS-1:0] number;
    logic                       row_end;
    logic                       list_end;
  } parse_result_t;

  // parser model plus the queue of results it still waits for
  class token_scoreboard;
    phase_e              phase;
    bit                  negative;
    bit [NUM_BITS-1:0]   magnitude;
    bit                  overflow;
    bit                  row_open;
    bit                  matrix_mode;
    parse_result_t       expected_q[$];
    int unsigned         err_count;
    int unsigned         results_checked;
    int unsigned         numbers_seen;
    int unsigned         rows_seen;

    function new();
      clear_number();
      row_open    = 1'b0;
      matrix_mode = 1'b0;
    endfunction

    function void clear_number();
      phase     = PH_IDLE;
      negative  = 1'b0;
      magnitude = '0;
      overflow  = 1'b0;
    endfunction

    function void set_mode(bit m);
      matrix_mode = m;
    endfunction

    // largest magnitude the current sign allows
    function bit [NUM_BITS-1:0] mag_limit();
      bit [NUM_BITS-1:0] half;
      half = NUM_BITS'(1) << (NUM_BITS - 1);
      return negative ? half : half - NUM_BITS'(1);
    endfunction

    function bit [NUM_BITS-1:0] finished_value();
      if (overflow || magnitude > mag_limit()) return '0;
      return negative ? -magnitude : magnitude;
    endfunction

    // one accepted byte: advance the parse and queue the result it causes
    function void note_char(logic [7:0] c, logic last);
      bit                is_digit;
      bit                semi;
      bit [NUM_BITS-1:0] digit;
      bit [NUM_BITS-1:0] lim;
      parse_result_t     res;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      semi     = matrix_mode && (c == CH_SEMI);
      res      = '0;
      if (is_digit) begin
        digit = NUM_BITS'(c - CH_ZERO);
        if (phase != PH_DIGITS) begin
          if (phase != PH_SIGN) negative = 1'b0;
          magnitude = '0;
          overflow  = 1'b0;
          phase     = PH_DIGITS;
        end
        lim = mag_limit();
        if (!overflow) begin
          if (magnitude > (lim - digit) / RADIX) overflow = 1'b1;
          else magnitude = magnitude * RADIX + digit;
        end
      end else begin
        if (phase == PH_DIGITS) begin
          res.value_valid = 1'b1;
          res.number      = finished_value();
        end
        clear_number();
        if (c == CH_PLUS || c == CH_MINUS) begin
          phase    = PH_SIGN;
          negative = (c == CH_MINUS);
        end
      end
      // row bookkeeping
      if (semi) begin
        res.row_end = 1'b1;
        row_open    = 1'b0;
      end else begin
        row_open = 1'b1;
      end
      // end of text flushes everything
      if (last) begin
        if (phase == PH_DIGITS) begin
          res.value_valid = 1'b1;
          res.number      = finished_value();
        end
        if (matrix_mode && row_open) res.row_end = 1'b1;
        res.list_end = 1'b1;
        clear_number();
        row_open = 1'b0;
      end
      if (res.value_valid || res.row_end || res.list_end) expected_q = {expected_q, res};
    endfunction

    // prints are capped so a broken block cannot flood the log
    task report(string msg);
      if (err_count < MAX_PRINTS) $display("MISMATCH: %s", msg);
      err_count++;
    endtask

    task check_result(logic vv, logic signed [NUM_BITS-1:0] num, logic re, logic le);
      parse_result_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result vv=%b num=%0d row_end=%b list_end=%b",
                         vv, num, re, le));
      end else begin
        exp_res = expected_q.pop_front();
        if (vv !== exp_res.value_valid)
          report($sformatf("result %0d value_valid %b, want %b",
                           results_checked, vv, exp_res.value_valid));
        if (num !== exp_res.number)
          report($sformatf("result %0d number %0d, want %0d",
                           results_checked, num, exp_res.number));
        if (re !== exp_res.row_end)
          report($sformatf("result %0d row_end %b, want %b",
                           results_checked, re, exp_res.row_end));
        if (le !== exp_res.list_end)
          report($sformatf("result %0d list_end %b, want %b",
                           results_checked, le, exp_res.list_end));
        if (exp_res.value_valid) numbers_seen++;
        if (exp_res.row_end) rows_seen++;
      end
      results_checked++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  ilt_char_if                          char_if ();
  ilt_res_if #(.VALUE_BITS(NUM_BITS))  res_if ();

  integer_list_tokenizer #(.VALUE_BITS(NUM_BITS)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .char_i      (char_if.sink),
    .res_o       (res_if.source)
  );

  token_scoreboard sb = new();

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned bytes_sent;
  int unsigned texts_built;
  int unsigned mode_writes;
  int unsigned stall_cycles;
  bit [8:0]    text_q[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result sink with random back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // monitor: each transaction goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) sb.set_mode(cfg_wdata);
      if (char_if.valid && char_if.ready) sb.note_char(char_if.char_code, char_if.is_last);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.value_valid, res_if.number, res_if.row_end, res_if.list_end);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function void push_byte(logic [7:0] c);
    text_q = {text_q, {1'b0, c}};
  endfunction

  function void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function void add_separator();
    case ($urandom_range(9))
      0: push_byte(CH_COMMA);
      1: begin
        push_byte(CH_COMMA);
        push_byte(CH_SPACE);
      end
      2: push_byte(CH_SPACE);
      3: push_byte(CH_SEMI);
      4: push_byte(CH_TAB);
      5: begin
        push_byte(CH_LF);
        push_byte(CH_CR);
      end
      6: push_byte(CH_VT);
      7: push_byte(CH_FF);
      8: begin
        push_byte(CH_SEMI);
        push_byte(CH_COMMA);
        push_byte(CH_COMMA);
      end
      default: push_byte(8'($urandom_range(255)));
    endcase
  endfunction

  // decimal number with optional sign and leading zeros, biased to range edges
  function void add_number();
    longint unsigned limit_vals[8];
    longint unsigned val;
    int unsigned     ndig;
    limit_vals = '{64'd0, 64'd2147483646, 64'd2147483647, 64'd2147483648, 64'd2147483649,
                   64'd4294967295, 64'd4294967296, 64'd9999999999};
    case ($urandom_range(2))
      1: push_byte(CH_PLUS);
      2: push_byte(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(7) == 0) repeat ($urandom_range(3, 1)) push_byte(CH_ZERO);
    case ($urandom_range(5))
      0: push_str($sformatf("%0d", $urandom_range(9)));
      1: push_str($sformatf("%0d", $urandom_range(99999)));
      2: push_str($sformatf("%0d", $urandom));
      3: push_str($sformatf("%0d", limit_vals[3'($urandom_range(7))]));
      4: begin
        ndig = $urandom_range(22, 11);
        repeat (ndig) push_byte(CH_ZERO + 8'($urandom_range(9)));
      end
      default: begin
        val = {$urandom, $urandom};
        push_str($sformatf("%0d", val));
      end
    endcase
  endfunction

  // one text: a few tokens, the final byte flagged as last
  function void add_text();
    int unsigned n;
    int unsigned start_size;
    int unsigned kind;
    n          = $urandom_range(6);
    start_size = text_q.size();
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        add_number();
        if (i < n - 1 || $urandom_range(1)) add_separator();
      end else if (kind < 82) begin
        push_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
        add_separator();
      end else begin
        repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
      end
    end
    if (text_q.size() == start_size) push_byte(8'($urandom_range(255)));
    text_q[text_q.size() - 1][8] = 1'b1;
    texts_built++;
  endfunction

  // one byte on the char channel, with random idle cycles ahead of it
  task send_byte(bit [8:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= b[7:0];
    char_if.is_last   <= b[8];
    do @(posedge clk_i); while (!char_if.ready);
    bytes_sent++;
  endtask

  // send n queued bytes, refilling with fresh texts, then drop valid
  task send_bytes(int unsigned n);
    repeat (n) begin
      if (text_q.size() == 0) add_text();
      send_byte(text_q.pop_front());
    end
    char_if.valid <= 1'b0;
  endtask

  // wait for all expected results, then for bytes that cause none to clear the pipe
  task drain_results();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task write_matrix_mode(bit m);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    mode_writes++;
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    char_if.is_last   <= 1'b0;
    tx_idle_pct       = 10;
    rx_stall_pct      = 82;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte extremes, whitespace, stacked and dangling signs, semicolon as junk
    write_matrix_mode(1'b0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_VT);
    push_byte(CH_FF);
    push_str("+-7;-,4");
    push_byte("2");
    text_q[text_q.size() - 1][8] = 1'b1;
    send_bytes(text_q.size());

    // directed: rows, empty row, dangling sign before a row end, open row closed at end
    write_matrix_mode(1'b1);
    push_str("9;;-;1,,");
    text_q[text_q.size() - 1][8] = 1'b1;
    push_byte(CH_SEMI);
    text_q[text_q.size() - 1][8] = 1'b1;
    push_byte(CH_X);
    text_q[text_q.size() - 1][8] = 1'b1;
    send_bytes(text_q.size());

    // random texts; segments may cut a text so the mode can change mid-text
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        tx_idle_pct  = 10;
        rx_stall_pct = 82;
      end else if (seg < 2 * SEGMENTS / 3) begin
        tx_idle_pct  = 82;
        rx_stall_pct = 10;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      write_matrix_mode(seg < 2 ? seg[0] : 1'($urandom_range(1)));
      send_bytes(SEG_BYTES);
    end
    send_bytes(text_q.size());

    drain_results();
    $display("covered %0d bytes in %0d texts with %0d mode writes",
             bytes_sent, texts_built, mode_writes);
    $display("checked %0d results: %0d numbers, %0d row ends, %0d mismatches",
             sb.results_checked, sb.numbers_seen, sb.rows_seen, sb.err_count);
    if (sb.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ilt_pkg.sv
design/ilt_if.sv
design/integer_list_tokenizer.sv
test/tb_top.sv
